@@ hdl/mck_pkg.sv @@
// Morse character keyer package: segment descriptor type, unit codes,
// queue sizing and the international Morse lookup table.
// No dependencies.
package mck_pkg;

   // Widths of the external fields
   localparam int CharW     = 8;
   localparam int DotTimeW  = 12;
   localparam int DurW      = 15;

   // Dot time after reset, in milliseconds
   localparam logic [DotTimeW-1:0] DotTimeReset = 12'd200;

   // Character codes of interest
   localparam logic [CharW-1:0] ChLowerA = 8'h61;
   localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
   localparam logic [CharW-1:0] ChUpperA = 8'h41;
   localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
   localparam logic [CharW-1:0] ChSpace  = 8'h20;
   localparam logic [CharW-1:0] CaseFold = 8'h20;

   // Descriptor queue between the front and back parts
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // Segment counter: up to four elements of two segments plus the letter gap
   localparam int MaxElems = 4;
   localparam int SegW     = $clog2(2 * MaxElems + 1);

   // Segment length in dot units
   typedef enum logic [1:0] {
      UNITS_ONE,
      UNITS_THREE,
      UNITS_SEVEN
   } units_type;

   // Morse pattern of one letter: element i is a dash when pattern[i] is set
   typedef struct packed {
      logic [2:0]          elem_cnt;
      logic [MaxElems-1:0] pattern;
   } morse_type;

   // Classified character as passed from front to back
   typedef struct packed {
      logic      is_space;
      morse_type morse;
   } desc_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // International Morse table, index 0 is A
   function automatic morse_type morse_lookup(input logic [4:0] idx);
      morse_type m;
      unique case (idx)
         5'd0:    m = '{3'd2, 4'b0010};  // A .-
         5'd1:    m = '{3'd4, 4'b0001};  // B -...
         5'd2:    m = '{3'd4, 4'b0101};  // C -.-.
         5'd3:    m = '{3'd3, 4'b0001};  // D -..
         5'd4:    m = '{3'd1, 4'b0000};  // E .
         5'd5:    m = '{3'd4, 4'b0100};  // F ..-.
         5'd6:    m = '{3'd3, 4'b0011};  // G --.
         5'd7:    m = '{3'd4, 4'b0000};  // H ....
         5'd8:    m = '{3'd2, 4'b0000};  // I ..
         5'd9:    m = '{3'd4, 4'b1110};  // J .---
         5'd10:   m = '{3'd3, 4'b0101};  // K -.-
         5'd11:   m = '{3'd4, 4'b0010};  // L .-..
         5'd12:   m = '{3'd2, 4'b0011};  // M --
         5'd13:   m = '{3'd2, 4'b0001};  // N -.
         5'd14:   m = '{3'd3, 4'b0111};  // O ---
         5'd15:   m = '{3'd4, 4'b0110};  // P .--.
         5'd16:   m = '{3'd4, 4'b1011};  // Q --.-
         5'd17:   m = '{3'd3, 4'b0010};  // R .-.
         5'd18:   m = '{3'd3, 4'b0000};  // S ...
         5'd19:   m = '{3'd1, 4'b0001};  // T -
         5'd20:   m = '{3'd3, 4'b0100};  // U ..-
         5'd21:   m = '{3'd4, 4'b1000};  // V ...-
         5'd22:   m = '{3'd3, 4'b0110};  // W .--
         5'd23:   m = '{3'd4, 4'b1001};  // X -..-
         5'd24:   m = '{3'd4, 4'b1101};  // Y -.--
         5'd25:   m = '{3'd4, 4'b0011};  // Z --..
         default: m = '{3'd0, 4'b0000};
      endcase
      return m;
   endfunction

endpackage

@@ hdl/mck_front.sv @@
// Front part of the Morse keyer: accepts character transactions,
// folds case and classifies them into queue descriptors.
// Depends on mck_pkg.
module mck_front import mck_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CharW-1:0] req_char_code,
   input  qstat_type        q_stat,
   output logic             push,
   output desc_type         push_desc
);

   logic [CharW-1:0] folded;
   logic             is_letter;
   logic [4:0]       letter_idx;
   logic [CharW-1:0] idx_full;

   // Hold the requester off while the queue has no room
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // Fold lower case to upper case
   always_comb begin
      if (req_char_code >= ChLowerA && req_char_code <= ChLowerZ) begin
         folded = req_char_code - CaseFold;
      end else begin
         folded = req_char_code;
      end
   end

   // Classify: letter, space or anything else
   assign is_letter  = (folded >= ChUpperA) && (folded <= ChUpperZ);
   assign idx_full   = folded - ChUpperA;
   assign letter_idx = idx_full[4:0];

   always_comb begin
      push_desc.is_space = (folded == ChSpace);
      if (is_letter) begin
         push_desc.morse = morse_lookup(letter_idx);
      end else begin
         push_desc.morse = '{3'd0, '0};
      end
   end

   // A transaction offered while the queue is full must not slip through
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("front pushed into a full queue");

endmodule

@@ hdl/mck_queue.sv @@
// Descriptor queue between the front and back parts of the Morse keyer.
// Small register FIFO with simultaneous push and pop.
// Depends on mck_pkg.
module mck_queue import mck_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  desc_type  push_desc,
   input  logic      pop,
   output qstat_type q_stat,
   output desc_type  head_desc
);

   desc_type           entries_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.full  = (count_ff == QCntW'(QueueDepth));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_desc    = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed descriptor
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QueueDepth))
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCntW'(QueueDepth)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with occupancy");

endmodule

@@ hdl/mck_back.sv @@
// Back part of the Morse keyer: walks the head descriptor one segment per
// cycle while the output is free and drives the registered segment output.
// Depends on mck_pkg.
module mck_back import mck_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [DotTimeW-1:0] unit_ms,
   input  qstat_type           q_stat,
   input  desc_type            head_desc,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_lamp_on,
   output logic [DurW-1:0]     rsp_duration_ms,
   output logic                rsp_last_segment
);

   logic [SegW-1:0] seg_ff, seg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            lamp_ff;
   logic [DurW-1:0] dur_ff;
   logic            last_ff;

   logic            head_valid;
   logic            out_free;
   logic            fire;
   logic            seg_lamp;
   logic            seg_last;
   units_type       seg_units;
   logic [SegW-1:0] elem_segs;
   logic [DurW-1:0] dot15, dur3, dur7, seg_dur;

   assign head_valid = !q_stat.empty;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = head_valid && out_free;
   assign pop        = fire && seg_last;
   assign elem_segs  = {head_desc.morse.elem_cnt, 1'b0};

   // Decode the current segment of the head descriptor
   always_comb begin
      seg_lamp  = 1'b0;
      seg_units = UNITS_THREE;
      seg_last  = 1'b1;
      if (head_desc.is_space) begin
         if (seg_ff == '0) begin
            seg_units = UNITS_SEVEN;
            seg_last  = 1'b0;
         end
      end else if (seg_ff < elem_segs) begin
         seg_last = 1'b0;
         if (!seg_ff[0]) begin
            seg_lamp  = 1'b1;
            seg_units = head_desc.morse.pattern[seg_ff[2:1]] ? UNITS_THREE : UNITS_ONE;
         end else begin
            seg_units = UNITS_ONE;
         end
      end
   end

   // Scale dot time by 1, 3 or 7 with shifts, an add and a subtract
   assign dot15 = DurW'(unit_ms);
   assign dur3  = dot15 + (dot15 << 1);
   assign dur7  = (dot15 << 3) - dot15;

   always_comb begin
      unique case (seg_units)
         UNITS_ONE:   seg_dur = dot15;
         UNITS_THREE: seg_dur = dur3;
         UNITS_SEVEN: seg_dur = dur7;
         default:     seg_dur = dot15;
      endcase
   end

   // Advance the segment counter, restart on the letter gap
   always_comb begin
      seg_in = seg_ff;
      if (fire) begin
         seg_in = seg_last ? '0 : seg_ff + 1'b1;
      end
   end

   // Output register: refill whenever it is empty or being taken
   assign rsp_valid_in = out_free ? head_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         lamp_ff <= seg_lamp;
         dur_ff  <= seg_dur;
         last_ff <= seg_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lamp_on      = lamp_ff;
   assign rsp_duration_ms  = dur_ff;
   assign rsp_last_segment = last_ff;

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      seg_ff <= SegW'(2 * MaxElems))
      else $error("segment counter out of range");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> seg_ff == '0)
      else $error("segment counter not cleared after letter gap");

   a_mid_item: assert property (@(posedge clock) disable iff (reset)
      seg_ff != '0 |-> head_valid)
      else $error("descriptor left the queue in the middle of a character");

endmodule

@@ hdl/morse_character_keyer.sv @@
// Morse character keyer top level: dot time register, front classifier,
// descriptor queue and back segment sequencer.
// Depends on mck_pkg, mck_front, mck_queue, mck_back.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      char_code[7:0]
//   rsp_      out        valid / stall      lamp_on, duration_ms[14:0], last_segment
//   csr_      in         valid / ready      dot_time_ms[11:0]
//
// A character is taken and queued; the back part sends one segment per cycle
// while the output is free: 2n+1 for a letter of n elements (3 to 9), 2 for a
// space, 1 for anything else. The result port sets the sustained rate. The
// queue holds four characters, so the front keeps taking input while the back
// is stalled, until the queue is full. Reset empties the queue and the output
// register and loads a dot time of 200 ms; the register write is always ready.
module morse_character_keyer import mck_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CharW-1:0]    req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_lamp_on,
   output logic [DurW-1:0]     rsp_duration_ms,
   output logic                rsp_last_segment,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DotTimeW-1:0] csr_dot_time_ms
);

   logic [DotTimeW-1:0] unit_ms_ff, unit_ms_in;
   qstat_type           q_stat;
   logic                push, pop;
   desc_type            push_desc, head_desc;

   // Dot time register, written on a csr transaction
   assign csr_ready  = 1'b1;
   assign unit_ms_in = (csr_valid && csr_ready) ? csr_dot_time_ms : unit_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff <= DotTimeReset;
      end else begin
         unit_ms_ff <= unit_ms_in;
      end
   end

   mck_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .q_stat        (q_stat),
      .push          (push),
      .push_desc     (push_desc)
   );

   mck_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .q_stat    (q_stat),
      .head_desc (head_desc)
   );

   mck_back u_back (
      .clock            (clock),
      .reset            (reset),
      .unit_ms          (unit_ms_ff),
      .q_stat           (q_stat),
      .head_desc        (head_desc),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lamp_on      (rsp_lamp_on),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

@@ test/morse_character_keyer_tb.sv @@
// Testbench for morse_character_keyer: directed characters, then random text under
// several dot times and idle and stall odds, every segment checked against expectations.
// Depends on mck_pkg and the keyer RTL.
`timescale 1ns / 100ps

module morse_character_keyer_tb import mck_pkg::*; ();

   localparam int  NumDirected = 20;
   localparam int  NumPhases   = 6;
   localparam int  MaxReported = 10;
   localparam int  SettleCap   = 20000;
   localparam int  DrainCycles = 16;
   localparam byte DashMark    = "-";

   // Segment fields exactly as the result port carries them
   typedef struct packed {
      logic            lamp_on;
      logic [DurW-1:0] duration_ms;
      logic            last_segment;
   } segment_type;

   // Expected segment, tagged with the character that caused it
   typedef struct packed {
      logic [CharW-1:0] code;
      segment_type      seg;
   } keyed_segment_type;

   // Directed row: typed_cnt zero means the local encoder supplies the segments
   typedef struct packed {
      logic [CharW-1:0]  code;
      logic [1:0]        typed_cnt;
      segment_type [0:2] typed;
   } char_row_type;

   // Run phase: dot time, sender idle and receiver stall odds in percent
   typedef struct packed {
      logic                rand_dot;
      logic [DotTimeW-1:0] dot;
      logic [7:0]          idle_pct;
      logic [7:0]          stall_pct;
      logic [7:0]          count;
   } phase_type;

   // Directed table; typed segments assume the reset dot time of 200 ms
   localparam char_row_type CharRows [NumDirected] = '{
      '{8'h00, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'hFF, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h80, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{ChSpace, 2'd2, '{'{1'b0, 15'd1400, 1'b0}, '{1'b0, 15'd600, 1'b1}, '0}},
      '{8'h45, 2'd3, '{'{1'b1, 15'd200, 1'b0}, '{1'b0, 15'd200, 1'b0},
                       '{1'b0, 15'd600, 1'b1}}},
      '{8'h74, 2'd3, '{'{1'b1, 15'd600, 1'b0}, '{1'b0, 15'd200, 1'b0},
                       '{1'b0, 15'd600, 1'b1}}},
      '{ChUpperA, 2'd0, '{'0, '0, '0}},
      '{ChUpperZ, 2'd0, '{'0, '0, '0}},
      '{ChLowerA, 2'd0, '{'0, '0, '0}},
      '{ChLowerZ, 2'd0, '{'0, '0, '0}},
      '{8'h40, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h5B, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h60, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h7B, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h51, 2'd0, '{'0, '0, '0}},
      '{8'h6A, 2'd0, '{'0, '0, '0}},
      '{8'h48, 2'd0, '{'0, '0, '0}},
      '{8'h79, 2'd0, '{'0, '0, '0}},
      '{8'h7F, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}},
      '{8'h30, 2'd1, '{'{1'b0, 15'd600, 1'b1}, '0, '0}}
   };

   localparam phase_type Phases [NumPhases] = '{
      '{1'b0, 12'd1,    8'd0,  8'd0,  8'd35},
      '{1'b0, 12'd4095, 8'd82, 8'd0,  8'd35},
      '{1'b0, 12'd0,    8'd0,  8'd82, 8'd35},
      '{1'b1, 12'd0,    8'd35, 8'd35, 8'd35},
      '{1'b0, 12'd4095, 8'd35, 8'd35, 8'd30},
      '{1'b1, 12'd0,    8'd0,  8'd82, 8'd30}
   };

   // International code, A first; a dash is '-', a dot '.'
   string letter_code [26] = '{
      ".-",   "-...", "-.-.", "-..",  ".",    "..-.", "--.",
      "....", "..",   ".---", "-.-",  ".-..", "--",   "-.",
      "---",  ".--.", "--.-", ".-.",  "...",  "-",    "..-",
      "...-", ".--",  "-..-", "-.--", "--.."
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CharW-1:0]    req_char_code;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_lamp_on;
   logic [DurW-1:0]     rsp_duration_ms;
   logic                rsp_last_segment;
   logic                csr_valid;
   logic                csr_ready;
   logic [DotTimeW-1:0] csr_dot_time_ms;

   logic [DotTimeW-1:0] dot_ms;
   keyed_segment_type   pending_segments[$];
   keyed_segment_type   oldest;
   int                  error_count;
   int                  send_idle_pct;
   int                  stall_pct;

   morse_character_keyer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lamp_on      (rsp_lamp_on),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_dot_time_ms  (csr_dot_time_ms)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MaxReported) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   // Append one expected segment of the given length in dot units
   function automatic void queue_segment(input logic [CharW-1:0] code, input logic lamp,
                                         input units_type units, input logic last);
      int            mult;
      segment_type   seg;
      mult = 1;
      case (units)
         UNITS_ONE:   mult = 1;
         UNITS_THREE: mult = 3;
         UNITS_SEVEN: mult = 7;
         default:     mult = 1;
      endcase
      seg.lamp_on      = lamp;
      seg.duration_ms  = DurW'(mult * int'(dot_ms));
      seg.last_segment = last;
      pending_segments.push_back('{code, seg});
   endfunction

   // Encode one character into its keying segments at the current dot time
   function automatic void key_character(input logic [CharW-1:0] code);
      logic [CharW-1:0] upper;
      string            pattern;
      upper = code;
      if (code >= ChLowerA && code <= ChLowerZ) begin
         upper = code - CaseFold;
      end
      if (upper >= ChUpperA && upper <= ChUpperZ) begin
         pattern = letter_code[upper - ChUpperA];
         for (int i = 0; i < pattern.len(); i++) begin
            queue_segment(code, 1'b1, (pattern[i] == DashMark) ? UNITS_THREE : UNITS_ONE,
                          1'b0);
            queue_segment(code, 1'b0, UNITS_ONE, 1'b0);
         end
      end else if (upper == ChSpace) begin
         queue_segment(code, 1'b0, UNITS_SEVEN, 1'b0);
      end
      queue_segment(code, 1'b0, UNITS_THREE, 1'b1);
   endfunction

   // Mostly letters of either case, some spaces, the rest any byte
   function automatic logic [CharW-1:0] pick_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return ($urandom_range(0, 1) ? ChUpperA : ChLowerA) + CharW'($urandom_range(0, 25));
      end else if (pick < 72) begin
         return ChSpace;
      end
      return CharW'($urandom_range(0, 255));
   endfunction

   // Offer one character transaction, idling first at random; queue its segments on accept
   task automatic send_char(input char_row_type row);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= row.code;
      do @(posedge clock); while (req_stall);
      if (row.typed_cnt == 2'd0) begin
         key_character(row.code);
      end else begin
         for (int k = 0; k < int'(row.typed_cnt); k++) begin
            pending_segments.push_back('{row.code, row.typed[k]});
         end
      end
   endtask

   // Drop valid once the last character is taken
   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait for every expected segment, flag leftovers, then let the pipe drain
   task automatic settle_results();
      int waited;
      waited = 0;
      while (pending_segments.size() != 0 && waited < SettleCap) begin
         @(posedge clock);
         waited++;
      end
      if (pending_segments.size() != 0) begin
         note_error($sformatf("%0d segments never arrived", pending_segments.size()));
         pending_segments.delete();
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_unit_ms(input logic [DotTimeW-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_dot_time_ms <= value;
      do @(posedge clock); while (!csr_ready);
      dot_ms = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Compare each accepted segment transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_segments.size() == 0) begin
            note_error($sformatf("unexpected segment lamp=%0b dur=%0d last=%0b",
                                 rsp_lamp_on, rsp_duration_ms, rsp_last_segment));
         end else begin
            oldest = pending_segments.pop_front();
            if (rsp_lamp_on !== oldest.seg.lamp_on ||
                rsp_duration_ms !== oldest.seg.duration_ms ||
                rsp_last_segment !== oldest.seg.last_segment) begin
               note_error($sformatf(
                  "char 0x%02h: exp lamp=%0b dur=%0d last=%0b, got lamp=%0b dur=%0d last=%0b",
                  oldest.code, oldest.seg.lamp_on, oldest.seg.duration_ms,
                  oldest.seg.last_segment, rsp_lamp_on, rsp_duration_ms, rsp_last_segment));
            end
         end
      end
   end

   // Hang guard
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      char_row_type row;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_code   = '0;
      csr_valid       = 1'b0;
      csr_dot_time_ms = '0;
      dot_ms          = DotTimeReset;
      error_count     = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed characters at the reset dot time
      for (int r = 0; r < NumDirected; r++) begin
         send_char(CharRows[r]);
      end
      end_burst();
      settle_results();

      // Random text under each dot time, idle and stall pattern
      for (int p = 0; p < NumPhases; p++) begin
         write_unit_ms(Phases[p].rand_dot ? DotTimeW'($urandom_range(1, 4095))
                                          : Phases[p].dot);
         send_idle_pct = Phases[p].idle_pct;
         stall_pct     = Phases[p].stall_pct;
         for (int n = 0; n < int'(Phases[p].count); n++) begin
            row           = '0;
            row.code      = pick_char();
            send_char(row);
         end
         end_burst();
         settle_results();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/mck_pkg.sv
hdl/mck_front.sv
hdl/mck_queue.sv
hdl/mck_back.sv
hdl/morse_character_keyer.sv
test/morse_character_keyer_tb.sv
